/* design/dotu_pkg.sv */
// Shared constants and types for the SMTP DATA dot unstuffer.
`timescale 1ns / 1ps
package dotu_pkg;

  localparam int          COUNT_BITS_DEF = 32;
  localparam logic [31:0] MAX_BYTES_RST  = 32'd10485760;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // register select, taken from paddr[2]
  localparam logic REG_MAX_BYTES = 1'b0;

  // result queue depth, power of two
  localparam int RESQ_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_END       = 2'd1,
    KIND_TOO_LARGE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } res_t;

endpackage

/* design/smtp_data_dot_unstuffer_unit.sv */
// SMTP DATA dot unstuffer top level: line state, size check, config port.
// Throughput: one byte per cycle while in_stall is low; the output side moves
// one result per transaction, so bytes giving two results are absorbed by a
// four-entry result queue, which registers every result before out_valid.
// Reset (synchronous, active low): line state and size total cleared,
// result queue emptied, max_bytes set to 10485760.
`timescale 1ns / 1ps
module smtp_data_dot_unstuffer_unit #(
  parameter int COUNT_BITS = dotu_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dotu_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [CB-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DOT   = 2'd1,
    PH_LINE  = 2'd2,
    PH_STRIP = 2'd3
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic          cr_held_r, cr_held_nxt;
  logic [CB-1:0] total_r, total_nxt;   // saturated appended + current line bytes
  logic [31:0]   max_bytes_r;

  logic          in_acc, cfg_wr, room2;
  logic          lf_end, big_now, big_inc, emit_b, rearm;
  logic [1:0]    inc, push_n, n_res;
  logic [CB:0]   tot_inc_w, tot_lf_w;
  logic [CB-1:0] tot_inc, tot_lf;
  phase_t        ph;
  res_t          e0, e1, head;
  logic          head_valid;

  function automatic phase_t advance(input phase_t p);
    phase_t r;
    case (p)
      PH_START: r = PH_LINE;
      PH_DOT:   r = PH_STRIP;
      default:  r = p;
    endcase
    return r;
  endfunction

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_BYTES);
  assign prdata = (paddr[2] == REG_MAX_BYTES) ? max_bytes_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
    end else if (cfg_wr) begin
      max_bytes_r <= pwdata;
    end
  end

  assign in_stall = !room2;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    lf_end    = cr_held_r && (in_byte == CH_LF);
    inc       = {1'b0, cr_held_r} + {1'b0, in_byte != CH_CR};
    tot_inc_w = {1'b0, total_r} + (CB+1)'(inc);
    tot_inc   = tot_inc_w[CB] ? CNT_MAX : tot_inc_w[CB-1:0];
    // finished line: CR LF added, removed dot taken off
    tot_lf_w  = {1'b0, total_r} + ((phase_r == PH_STRIP) ? (CB+1)'(1) : (CB+1)'(2));
    tot_lf    = tot_lf_w[CB] ? CNT_MAX : tot_lf_w[CB-1:0];
    big_now   = CMP_W'(total_r) > CMP_W'(max_bytes_r);
    big_inc   = CMP_W'(tot_inc) > CMP_W'(max_bytes_r);

    ph          = cr_held_r ? advance(phase_r) : phase_r;
    emit_b      = 1'b0;
    cr_held_nxt = 1'b0;
    if (in_byte == CH_CR) begin
      cr_held_nxt = 1'b1;
    end else if (ph == PH_START && in_byte == CH_DOT) begin
      ph = PH_DOT;
    end else begin
      ph     = advance(ph);
      emit_b = 1'b1;
    end

    e0    = '{data: CH_CR, kind: KIND_DATA, last: 1'b0};
    e1    = '{data: in_byte, kind: KIND_DATA, last: 1'b1};
    rearm = 1'b0;
    n_res = 2'd0;
    phase_nxt = ph;
    total_nxt = tot_inc;

    if (lf_end) begin
      cr_held_nxt = 1'b0;
      if (big_now) begin
        e0    = '{data: 8'd0, kind: KIND_TOO_LARGE, last: 1'b1};
        n_res = 2'd1;
        rearm = 1'b1;
      end else if (phase_r == PH_DOT) begin
        e0    = '{data: 8'd0, kind: KIND_END, last: 1'b1};
        n_res = 2'd1;
        rearm = 1'b1;
      end else begin
        e1        = '{data: CH_LF, kind: KIND_DATA, last: 1'b1};
        n_res     = 2'd2;
        phase_nxt = PH_START;
        total_nxt = tot_lf;
      end
    end else if (big_inc) begin
      e0    = '{data: 8'd0, kind: KIND_TOO_LARGE, last: 1'b1};
      n_res = 2'd1;
      rearm = 1'b1;
    end else begin
      n_res = {1'b0, cr_held_r} + {1'b0, emit_b};
      if (!cr_held_r) begin
        e0 = '{data: in_byte, kind: KIND_DATA, last: 1'b1};
      end else if (!emit_b) begin
        e0.last = 1'b1;
      end
    end

    if (rearm) begin
      phase_nxt   = PH_START;
      cr_held_nxt = 1'b0;
      total_nxt   = '0;
    end
    push_n = in_acc ? n_res : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      cr_held_r <= 1'b0;
      total_r   <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      cr_held_r <= cr_held_nxt;
      total_r   <= total_nxt;
    end
  end

  dotu_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_e0    (e0),
    .push_e1    (e1),
    .room2      (room2),
    .head_valid (head_valid),
    .head       (head),
    .pop        (!out_stall)
  );

  assign out_valid    = head_valid;
  assign out_byte     = head.data;
  assign out_kind     = head.kind;
  assign out_run_last = head.last;

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && rearm |=> total_r == '0 && phase_r == PH_START && !cr_held_r)
    else $error("state not cleared after end or too-large result");

  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_run_last && out_byte == 8'd0)
    else $error("control result not alone or carries data");

  a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && lf_end && !rearm |=> phase_r == PH_START && !cr_held_r)
    else $error("line not closed on CR LF");

endmodule

/* design/dotu_resq.sv */
// Result queue: takes up to two results per cycle, delivers one per transaction.
`timescale 1ns / 1ps
module dotu_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  dotu_pkg::res_t push_e0,
  input  dotu_pkg::res_t push_e1,
  output logic          room2,
  output logic          head_valid,
  output dotu_pkg::res_t head,
  input  logic          pop
);
  import dotu_pkg::*;

  localparam int PW = $clog2(RESQ_DEPTH);
  localparam int CW = $clog2(RESQ_DEPTH + 1);

  res_t          mem_r [RESQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room2      = (cnt_r <= CW'(RESQ_DEPTH - 2));
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
    cnt_nxt    = cnt_r + CW'(push_n) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_e0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push_e1;
    end
  end

endmodule

/* dv/smtp_data_dot_unstuffer_unit_tb.sv */
// Self-checking testbench for the SMTP DATA dot unstuffer: predictor, driver, monitor.
`timescale 1ns / 1ps
module smtp_data_dot_unstuffer_unit_tb;
  import dotu_pkg::*;

  typedef enum logic [1:0] {
    PH_START    = 2'd0,
    PH_LONE_DOT = 2'd1,
    PH_PLAIN    = 2'd2,
    PH_STRIPPED = 2'd3
  } line_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  smtp_data_dot_unstuffer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_kind(out_kind), .out_run_last(out_run_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] max_limit = MAX_BYTES_RST;
  line_phase_t line_phase = PH_START;
  logic        cr_held = 1'b0;
  logic [31:0] appended_bytes = 32'd0;
  logic [31:0] line_bytes = 32'd0;

  logic [7:0] raw_bytes[$];
  res_t       predicted_results[$];

  int errors = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int n_data = 0, n_end = 0, n_big = 0;
  int n_settings = 0;
  logic byte_taken = 1'b0;
  logic hold_input = 1'b0;
  int hold_requests = 0;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic oversize();
    return sat_add(appended_bytes, line_bytes) > max_limit;
  endfunction

  function automatic line_phase_t into_line(input line_phase_t ph);
    if (ph == PH_START) return PH_PLAIN;
    if (ph == PH_LONE_DOT) return PH_STRIPPED;
    return ph;
  endfunction

  function automatic void rearm_line();
    line_phase = PH_START;
    cr_held = 1'b0;
    appended_bytes = 32'd0;
    line_bytes = 32'd0;
  endfunction

  function automatic void unstuff_byte(input logic [7:0] b);
    res_t run[$];
    line_phase_t ph;
    logic [31:0] kept;
    ph = line_phase;
    if (cr_held && b == CH_LF) begin
      if (oversize()) begin
        run.push_back('{8'h00, KIND_TOO_LARGE, 1'b0});
        rearm_line();
      end else if (ph == PH_LONE_DOT) begin
        run.push_back('{8'h00, KIND_END, 1'b0});
        rearm_line();
      end else begin
        kept = line_bytes;
        if (ph == PH_STRIPPED && kept != 0) kept = kept - 1;
        appended_bytes = sat_add(sat_add(appended_bytes, kept), 32'd2);
        line_bytes = 32'd0;
        line_phase = PH_START;
        cr_held = 1'b0;
        run.push_back('{CH_CR, KIND_DATA, 1'b0});
        run.push_back('{CH_LF, KIND_DATA, 1'b0});
      end
    end else begin
      if (cr_held) begin
        // held CR turns out to be data
        line_bytes = sat_add(line_bytes, 32'd1);
        ph = into_line(ph);
        run.push_back('{CH_CR, KIND_DATA, 1'b0});
        cr_held = 1'b0;
      end
      if (b == CH_CR) begin
        cr_held = 1'b1;
      end else if (ph == PH_START && b == CH_DOT) begin
        ph = PH_LONE_DOT;
        line_bytes = sat_add(line_bytes, 32'd1);
      end else begin
        line_bytes = sat_add(line_bytes, 32'd1);
        ph = into_line(ph);
        run.push_back('{b, KIND_DATA, 1'b0});
      end
      line_phase = ph;
      if (oversize()) begin
        run.delete();
        run.push_back('{8'h00, KIND_TOO_LARGE, 1'b0});
        rearm_line();
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) predicted_results.push_back(run[i]);
  endfunction

  // monitor: check results, then predict for the accepted byte
  always @(posedge clk) begin : monitor
    res_t want;
    byte_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          errors++;
          $error("unexpected result: out_byte %0h out_kind %0d", out_byte, out_kind);
        end else begin
          want = predicted_results.pop_front();
          if (out_byte !== want.data) begin
            errors++;
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          end
          if (out_kind !== want.kind) begin
            errors++;
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          end
          if (out_run_last !== want.last) begin
            errors++;
            $error("out_run_last: expected %0b, got %0b", want.last, out_run_last);
          end
          case (want.kind)
            KIND_DATA: n_data++;
            KIND_END:  n_end++;
            default:   n_big++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        raw_bytes.delete(0);
        unstuff_byte(in_byte);
        bytes_taken++;
      end
    end
  end

  // driver: bursts with random gaps
  always @(negedge clk) begin : driver
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 30);
      gap_left = 0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (hold_input || raw_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_byte <= raw_bytes[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  always @(negedge clk) begin : staller
    int hold_served;
    int hold_left;
    int mode_left;
    int stall_mode;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_served = 0;
      hold_left = 0;
      mode_left = 0;
      stall_mode = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_MAX_BYTES, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_max_bytes();
    logic [31:0] rd;
    apb_xfer(1'b0, 32'd0, rd);
    if (rd !== max_limit) begin
      errors++;
      $error("max_bytes: expected %0d, got %0d", max_limit, rd);
    end
  endtask

  task automatic set_max_bytes(input logic [31:0] v);
    logic [31:0] rd;
    apb_xfer(1'b1, v, rd);
    max_limit = v;
    n_settings++;
    check_max_bytes();
  endtask

  task automatic wait_idle();
    while (raw_bytes.size() != 0 || in_valid) @(negedge clk);
    while (predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void push_byte(input logic [7:0] b);
    raw_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_text(input string s);
    foreach (s[i]) push_byte(s[i]);
  endfunction

  function automatic void push_line(input string s);
    push_text(s);
    push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  function automatic void queue_message();
    int n_lines;
    int len;
    logic [7:0] c;
    n_lines = $urandom_range(0, 5);
    for (int l = 0; l < n_lines; l++) begin
      if ($urandom_range(0, 3) == 0) push_byte(CH_DOT);
      len = $urandom_range(0, 10);
      for (int k = 0; k < len; k++) begin
        c = 8'($urandom_range(0, 255));
        push_byte(c);
        if (c == CH_CR) push_byte(8'h20);   // bare CR stays data
      end
      push_byte(CH_CR);
      push_byte(CH_LF);
    end
    if ($urandom_range(0, 9) != 0) push_line(".");
  endfunction

  function automatic void queue_noise();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0: push_byte(CH_CR);
        1: push_byte(CH_LF);
        2: push_byte(CH_DOT);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void queue_random(input int n);
    int target;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      if ($urandom_range(0, 19) < 17) queue_message();
      else queue_noise();
    end
  endfunction

  initial begin : stimulus
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_max_bytes();

    // end of message, stuffed dot, bare CR and CR CR, lone dot then data CR
    push_line(".");
    push_line("..a");
    push_text("x");
    push_byte(CH_CR);
    push_text("y");
    push_byte(CH_CR);
    push_line("");
    push_byte(CH_LF);
    push_text(".");
    push_byte(CH_CR);
    push_line(".");
    push_text("abcd");
    push_byte(CH_CR);
    wait_idle();
    // limit lowered under a held CR: the LF gives the too-large result
    set_max_bytes(32'd2);
    push_byte(CH_LF);
    wait_idle();
    // held CR proves to be data and pushes the line over the limit
    set_max_bytes(32'd4);
    push_text("abc");
    push_byte(CH_CR);
    push_text("X");
    queue_random(80);
    wait_idle();

    set_max_bytes(32'd0);
    queue_random(100);
    wait_idle();

    set_max_bytes(32'hFFFF_FFFF);
    queue_random(300);
    hold_requests++;
    while (raw_bytes.size() > 120) @(negedge clk);
    hold_input = 1'b1;
    while (in_valid || predicted_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    hold_input = 1'b0;
    wait_idle();

    set_max_bytes($urandom_range(5, 80));
    queue_random(200);
    wait_idle();
    set_max_bytes($urandom_range(5, 80));
    queue_random(200);
    wait_idle();

    set_max_bytes($urandom_range(100, 2000));
    queue_random(400);
    wait_idle();

    repeat (10) @(negedge clk);
    if (predicted_results.size() != 0) begin
      errors++;
      $error("%0d expected results never arrived", predicted_results.size());
    end
    $display("Run covered %0d bytes over %0d max_bytes settings", bytes_taken, n_settings);
    $display("Results seen: %0d data, %0d end of message, %0d too large", n_data, n_end, n_big);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
design/dotu_pkg.sv
design/dotu_resq.sv
design/smtp_data_dot_unstuffer_unit.sv
dv/smtp_data_dot_unstuffer_unit_tb.sv
